/* rtl/assert_macros.svh */
// assertion macros shared by the heap rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* rtl/sth_pkg.sv */
// types and constants for the ternary min-heap
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sth_pkg;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  // one stored word: elevation, age, row, col
  typedef struct packed {
    logic signed [31:0] elev;
    logic [31:0]        age;
    logic [11:0]        row;
    logic [11:0]        col;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_C1, S_DN_C2, S_DN_C3, S_DN_MV,
    S_LAST_RD, S_LAST_WAIT, S_DONE
  } state_t;

  // controller commands
  typedef struct packed {
    logic load_ins;    // take input word, hole at count
    logic rd_parent;   // read parent of hole
    logic up_move;     // move parent down into hole, hole := parent
    logic up_place;    // write held word at hole
    logic pop_start;   // latch root as result, hole := 0
    logic rd_child;    // read child k+1 of hole
    logic cmp_child;   // compare read word against best
    logic dn_move;     // move best into hole
    logic rd_last;     // read last entry into held word
    logic cnt_inc;
    logic cnt_dec;
    logic clr_out;
    logic [1:0] k;
  } cmd_t;

  // datapath status
  typedef struct packed {
    logic empty;
    logic full;
    logic one;
    logic hole_root;
    logic held_first;  // held word sorts before read word
    logic child_ok;    // child k exists
    logic has_child;   // first child exists
    logic hole_lt_last;
  } sts_t;

  function automatic logic key_before(entry_t a, entry_t b);
    if (a.elev == b.elev) return a.age < b.age;
    return a.elev < b.elev;
  endfunction
endpackage
`default_nettype wire

/* rtl/sth_datapath.sv */
// heap memory, indices, count and result registers
// depends on sth_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sth_datapath #(
  parameter int CAPACITY = 4096,
  parameter int AW = 12,
  parameter int CW = 13
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sth_pkg::cmd_t cmd,
  output sth_pkg::sts_t sts,
  input  wire logic [11:0] in_row,
  input  wire logic [11:0] in_col,
  input  wire logic signed [31:0] in_elevation,
  input  wire logic [1:0] out_status_nxt,
  input  wire logic out_load,
  output logic [1:0] out_status,
  output logic [11:0] out_row,
  output logic [11:0] out_col,
  output logic signed [31:0] out_elevation,
  output logic [CW-1:0] out_occupancy
);
  import sth_pkg::*;

  // reciprocal of three, exact for every CW-bit index
  localparam logic [CW-1:0] DIV3_M = CW'(((64'd1 << (CW + 1)) + 64'd2) / 64'd3);

  entry_t mem [CAPACITY];
  entry_t rd_r, held_r, best_r, res_r;
  logic [CW-1:0] cnt_r, hole_r, best_idx_r, rd_idx;
  logic [31:0] age_r;
  logic [CW+1:0] child0;
  logic [CW+1:0] childk;
  logic [CW-1:0] par;
  logic [CW-1:0] hole_m1;
  logic [2*CW-1:0] par_prod;

  assign child0 = {hole_r, 1'b0, 1'b0} - {2'b0, hole_r} + (CW+2)'(1); // 3*hole+1
  assign childk = child0 + {{CW{1'b0}}, cmd.k};

  // parent = (hole - 1) / 3 by multiply and shift
  assign hole_m1 = hole_r - 1'b1;
  assign par_prod = {{CW{1'b0}}, hole_m1} * {{CW{1'b0}}, DIV3_M};
  assign par = {1'b0, par_prod[2*CW-1:CW+1]};

  // read address select
  always_comb begin
    if (cmd.rd_parent) rd_idx = par;
    else if (cmd.rd_last) rd_idx = cnt_r - 1'b1;
    else if (cmd.rd_child) rd_idx = childk[CW-1:0] + 1'b1;
    else rd_idx = childk[CW-1:0];
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_idx[AW-1:0]];
    if (cmd.load_ins) begin
    end
    if (cmd.up_move) mem[hole_r[AW-1:0]] <= rd_r;
    else if (cmd.up_place) mem[hole_r[AW-1:0]] <= held_r;
    else if (cmd.dn_move) mem[hole_r[AW-1:0]] <= best_r;
  end

  // indices and held words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      age_r <= '0;
    end else begin
      if (cmd.load_ins) begin
        held_r <= '{elev: in_elevation, age: age_r, row: in_row, col: in_col};
        hole_r <= cnt_r;
        age_r <= age_r + 1'b1;
      end
      if (cmd.up_move) hole_r <= par;
      if (cmd.pop_start) begin
        res_r <= mem[0];
        hole_r <= '0;
      end
      if (cmd.cmp_child) begin
        if (cmd.k == 2'd0 || key_before(rd_r, best_r)) begin
          best_r <= rd_r;
          best_idx_r <= childk[CW-1:0];
        end
      end
      if (cmd.dn_move) hole_r <= best_idx_r;
      if (cmd.rd_last) held_r <= rd_r;
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (cmd.cnt_dec) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign sts.empty = (cnt_r == '0);
  assign sts.full = ({{32-CW{1'b0}}, cnt_r} >= 32'(CAPACITY));
  assign sts.one = (cnt_r == CW'(1));
  assign sts.hole_root = (hole_r == '0);
  assign sts.held_first = key_before(held_r, rd_r);
  assign sts.child_ok = (childk < {2'b0, cnt_r});
  assign sts.has_child = (child0 < {2'b0, cnt_r});
  assign sts.hole_lt_last = (hole_r < cnt_r - 1'b1);

  // result registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_nxt;
      out_occupancy <= cnt_r;
      if (cmd.clr_out) begin
        out_row <= '0; out_col <= '0; out_elevation <= '0;
      end else begin
        out_row <= res_r.row; out_col <= res_r.col; out_elevation <= res_r.elev;
      end
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, {{32-CW{1'b0}}, cnt_r} > 32'(CAPACITY))
  `ASSERT_IMPL(a_inc_dec, clk, rst_n, !(cmd.cnt_inc && cmd.cnt_dec))
  `ASSERT_IMPL(a_one_write, clk, rst_n, !(cmd.up_move && cmd.dn_move))
endmodule
`default_nettype wire

/* rtl/sth_ctrl.sv */
// heap sequencer: sift up on insert, hole walk then sift up on pop
// depends on sth_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sth_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_mode,
  output logic busy,
  input  wire sth_pkg::sts_t sts,
  output sth_pkg::cmd_t cmd,
  output logic [1:0] status_nxt,
  output logic out_load,
  output logic out_valid
);
  import sth_pkg::*;
  state_t state_r, state_nxt;
  logic [1:0] st_r, st_nxt;
  logic clr_r, clr_nxt;
  logic go;
  assign go = start && !busy;
  assign busy = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r; st_nxt = st_r; clr_nxt = clr_r;
    unique case (state_r)
      S_IDLE: if (go) begin
        st_nxt = ST_OK; clr_nxt = 1'b1;
        if (in_mode == MODE_INSERT) begin
          if (sts.full) begin st_nxt = ST_FULL; state_nxt = S_DONE; end
          else state_nxt = S_UP_RD;
        end else if (sts.empty) begin
          st_nxt = ST_EMPTY; state_nxt = S_DONE;
        end else begin
          clr_nxt = 1'b0;
          state_nxt = sts.one ? S_DONE : S_DN_RD;
        end
      end
      S_UP_RD: state_nxt = sts.hole_root ? S_DONE : S_UP_CMP;
      S_UP_CMP: state_nxt = sts.held_first ? S_UP_RD : S_DONE;
      S_DN_RD: state_nxt = sts.has_child ? S_DN_C1 : S_LAST_RD;
      S_DN_C1: state_nxt = S_DN_C2;
      S_DN_C2: state_nxt = S_DN_C3;
      S_DN_C3: state_nxt = S_DN_MV;
      S_DN_MV: state_nxt = S_DN_RD;
      S_LAST_RD: state_nxt = S_LAST_WAIT;
      S_LAST_WAIT: state_nxt = sts.hole_lt_last ? S_UP_RD : S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs; S_DN_C1..C3 compare child k read the cycle before, and C1 and C2 also read child k+1
  always_comb begin
    cmd = '0;
    cmd.clr_out = clr_r;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: if (go && in_mode == MODE_INSERT && !sts.full) begin
        cmd.load_ins = 1'b1; cmd.cnt_inc = 1'b1;
      end else if (go && in_mode == MODE_POP && !sts.empty) begin
        cmd.pop_start = 1'b1;
        if (sts.one) cmd.cnt_dec = 1'b1;
      end
      S_UP_RD: if (!sts.hole_root) cmd.rd_parent = 1'b1;
               else cmd.up_place = 1'b1;
      S_UP_CMP: if (sts.held_first) cmd.up_move = 1'b1;
                else cmd.up_place = 1'b1;
      S_DN_RD: if (sts.has_child) cmd.k = 2'd0;
               else cmd.rd_last = 1'b0;
      S_DN_C1: begin cmd.cmp_child = 1'b1; cmd.k = 2'd0; cmd.rd_child = 1'b1; end
      S_DN_C2: begin cmd.k = 2'd1; cmd.cmp_child = sts.child_ok; cmd.rd_child = 1'b1; end
      S_DN_C3: begin cmd.k = 2'd2; cmd.cmp_child = sts.child_ok; end
      S_DN_MV: cmd.dn_move = 1'b1;
      S_LAST_RD: cmd.rd_last = 1'b1;
      S_LAST_WAIT: begin
        cmd.rd_last = 1'b1; cmd.cnt_dec = 1'b1;
        if (!sts.hole_lt_last) cmd.up_place = 1'b0;
      end
      S_DONE: out_load = 1'b1;
      default: ;
    endcase
    status_nxt = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; st_r <= ST_OK; clr_r <= 1'b1; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; st_r <= st_nxt; clr_r <= clr_nxt; out_valid <= out_load;
    end
  end

  `ASSERT_IMPL(a_busy_hold, clk, rst_n, go |=> busy)
  `ASSERT_IMPL(a_done_idle, clk, rst_n, (state_r == S_DONE) |=> !busy)
  `ASSERT_IMPL(a_valid_pulse, clk, rst_n, out_valid |=> !out_valid)
endmodule
`default_nettype wire

/* rtl/stable_ternary_min_heap.sv */
// ternary min-heap priority queue with age tie break, top level
// depends on sth_pkg, sth_ctrl, sth_datapath
`timescale 1ns / 1ps
`default_nettype none
// usage:
//   drive in_mode/in_row/in_col/in_elevation with start high while busy is
//   low; the word is taken at that edge. in_mode 0 inserts, 1 pops the entry
//   with lowest elevation (older entry first on ties).
//   one result per word: out_valid is high for exactly one cycle with
//   out_status, out_row, out_col, out_elevation and out_occupancy.
//   the receiver cannot stall; results are never held back.
//   an insert climbs from the new slot toward the root; a pop walks the hole
//   from the root down along the smallest child, then moves the last entry
//   into the hole and sifts it up when it has to. the walk is paced by the
//   registered read port of the heap memory (one child read per cycle).
//   one word is in work at a time.
//   a full-heap insert, an empty pop or a pop of the only entry goes
//   straight to the done state without a heap walk.
//   reset empties the heap and clears the age counter at once; memory
//   contents are not cleared, only the fill count matters.
module stable_ternary_min_heap #(
  parameter int CAPACITY = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic in_mode,
  input  wire logic [11:0] in_row,
  input  wire logic [11:0] in_col,
  input  wire logic signed [31:0] in_elevation,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [11:0] out_row,
  output logic [11:0] out_col,
  output logic signed [31:0] out_elevation,
  output logic [$clog2(CAPACITY+1)-1:0] out_occupancy
);
  import sth_pkg::*;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  cmd_t cmd;
  sts_t sts;
  logic [1:0] status_nxt;
  logic out_load;

  sth_ctrl u_ctrl (.clk, .rst_n, .start, .in_mode, .busy, .sts, .cmd,
    .status_nxt, .out_load, .out_valid);

  sth_datapath #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_dp (.clk, .rst_n,
    .cmd, .sts, .in_row, .in_col, .in_elevation, .out_status_nxt(status_nxt),
    .out_load, .out_status, .out_row, .out_col, .out_elevation, .out_occupancy);
endmodule
`default_nettype wire

/* test/tb_stable_ternary_min_heap.sv */
// self-checking testbench for the ternary min-heap priority queue
// depends on sth_pkg and stable_ternary_min_heap; predicts with its own heap
`timescale 1ns / 1ps
`default_nettype none
module tb_stable_ternary_min_heap;
  import sth_pkg::*;

  localparam int DEPTH = 4096;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = MODE_INSERT;
  logic [11:0] in_row = '0;
  logic [11:0] in_col = '0;
  logic signed [31:0] in_elevation = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [11:0] out_row;
  logic [11:0] out_col;
  logic signed [31:0] out_elevation;
  logic [12:0] out_occupancy;

  stable_ternary_min_heap #(.CAPACITY(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_row(in_row), .in_col(in_col),
    .in_elevation(in_elevation), .out_valid(out_valid),
    .out_status(out_status), .out_row(out_row), .out_col(out_col),
    .out_elevation(out_elevation), .out_occupancy(out_occupancy)
  );

  typedef struct packed {
    logic [1:0]         status;
    logic [11:0]        row;
    logic [11:0]        col;
    logic signed [31:0] elev;
    logic [12:0]        occ;
  } pop_word_t;

  typedef struct packed {
    logic               mode;
    logic [11:0]        row;
    logic [11:0]        col;
    logic signed [31:0] elev;
    logic               fixed;   // expected word typed in below
    pop_word_t          want;
  } stim_row_t;

  // predictor state
  entry_t    shadow_heap [DEPTH];
  int unsigned shadow_count = 0;
  logic [31:0] shadow_age = '0;
  pop_word_t pending_words [$];
  int        mismatches = 0;
  int        words_sent = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit sorts_first(entry_t a, entry_t b);
    if (a.elev == b.elev) return a.age < b.age;
    return a.elev < b.elev;
  endfunction

  function automatic void sift_up(int unsigned pos);
    entry_t held;
    int unsigned parent;
    held = shadow_heap[pos];
    while (pos > 0) begin
      parent = (pos - 1) / 3;
      if (!sorts_first(held, shadow_heap[parent])) break;
      shadow_heap[pos] = shadow_heap[parent];
      pos = parent;
    end
    shadow_heap[pos] = held;
  endfunction

  // apply one word to the shadow heap, return expected result
  function automatic pop_word_t heap_apply(logic mode, logic [11:0] row, logic [11:0] col,
                                           logic signed [31:0] elev);
    pop_word_t res;
    int unsigned hole, best, k, last;
    res = '0;
    if (mode == MODE_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow_heap[shadow_count] = '{elev: elev, age: shadow_age, row: row, col: col};
        shadow_age++;
        shadow_count++;
        sift_up(shadow_count - 1);
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.row = shadow_heap[0].row;
      res.col = shadow_heap[0].col;
      res.elev = shadow_heap[0].elev;
      if (shadow_count > 1) begin
        hole = 0;
        // hole walks down along smallest child
        while (3 * hole + 1 < shadow_count) begin
          best = 3 * hole + 1;
          for (k = best + 1; k < shadow_count && k <= 3 * hole + 3; k++)
            if (sorts_first(shadow_heap[k], shadow_heap[best])) best = k;
          shadow_heap[hole] = shadow_heap[best];
          hole = best;
        end
        last = shadow_count - 1;
        if (hole < last) begin
          shadow_heap[hole] = shadow_heap[last];
          sift_up(hole);
        end
      end
      shadow_count--;
    end
    res.occ = 13'(shadow_count);
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    pop_word_t got, want;
    if (rst_n && out_valid) begin
      got = '{status: out_status, row: out_row, col: out_col, elev: out_elevation,
              occ: out_occupancy};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // send one word, wait for acceptance
  task automatic send_word(logic mode, logic [11:0] row, logic [11:0] col,
                           logic signed [31:0] elev, bit fixed, pop_word_t want);
    pop_word_t pred;
    start <= 1'b1;
    in_mode <= mode;
    in_row <= row;
    in_col <= col;
    in_elevation <= elev;
    do @(posedge clk); while (busy);
    pred = heap_apply(mode, row, col, elev);
    if (fixed && pred !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("table mismatch: expected %p predicted %p", want, pred);
    end
    pending_words.push_back(fixed ? want : pred);
    words_sent++;
  endtask

  task automatic idle_some(bit allow);
    if (allow && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic pop_word_t word_of(logic [1:0] st, logic [11:0] r, logic [11:0] c,
                                        logic signed [31:0] e, int unsigned occ);
    return '{status: st, row: r, col: c, elev: e, occ: 13'(occ)};
  endfunction

  stim_row_t directed [$];

  initial begin
    int n, p;
    logic [11:0] r;
    logic signed [31:0] e;
    // directed table: empty pop, extremes, ties, predicted rows
    directed.push_back('{MODE_POP, 12'hfff, 12'hfff, -32'sd1, 1'b1,
                         word_of(ST_EMPTY, 12'h000, 12'h000, 32'sd0, 0)});
    directed.push_back('{MODE_INSERT, 12'hfff, 12'h000, 32'sh7fffffff, 1'b1,
                         word_of(ST_OK, 12'h000, 12'h000, 32'sd0, 1)});
    directed.push_back('{MODE_INSERT, 12'h000, 12'hfff, 32'sh80000000, 1'b1,
                         word_of(ST_OK, 12'h000, 12'h000, 32'sd0, 2)});
    directed.push_back('{MODE_POP, 12'h000, 12'h000, 32'sd0, 1'b1,
                         word_of(ST_OK, 12'h000, 12'hfff, 32'sh80000000, 1)});
    directed.push_back('{MODE_POP, 12'h000, 12'h000, 32'sd0, 1'b1,
                         word_of(ST_OK, 12'hfff, 12'h000, 32'sh7fffffff, 0)});
    directed.push_back('{MODE_POP, 12'h000, 12'h000, 32'sd0, 1'b1,
                         word_of(ST_EMPTY, 12'h000, 12'h000, 32'sd0, 0)});
    // equal elevations: older first
    for (int i = 0; i < 5; i++)
      directed.push_back('{MODE_INSERT, 12'(i + 1), 12'(i + 10), 32'sd5, 1'b0, '0});
    directed.push_back('{MODE_INSERT, 12'haaa, 12'h555, -32'sd3, 1'b0, '0});
    directed.push_back('{MODE_INSERT, 12'h555, 12'haaa, 32'sd0, 1'b0, '0});
    for (int i = 0; i < 8; i++)
      directed.push_back('{MODE_POP, 12'h000, 12'h000, 32'sd0, 1'b0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].mode, directed[i].row, directed[i].col, directed[i].elev,
                directed[i].fixed, directed[i].want);
    drain();

    // random mix; no idling in the first stretch
    n = 0;
    while (n < 1080) begin
      p = (shadow_count > 40) ? 60 : (shadow_count < 5 ? 20 : 45);
      if ($urandom_range(99) < p) begin
        send_word(MODE_POP, 12'($urandom), 12'($urandom), 32'($urandom), 1'b0, '0);
      end else begin
        r = 12'($urandom);
        case ($urandom_range(3))
          0: e = 32'($urandom_range(0, 3));
          1: e = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
          default: e = 32'($urandom);
        endcase
        send_word(MODE_INSERT, r, 12'($urandom), e, 1'b0, '0);
      end
      n++;
      if (n == 550) drain();   // sender holds until all results are in
      idle_some(n > 200);
    end
    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("stable_ternary_min_heap regression: pass");
    end else begin
      $display("stable_ternary_min_heap regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("stable_ternary_min_heap regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
